[rtl/srb_pkg.sv]
// Shared types and constants of the spectrum row binning block.
// Holds the opcodes, the sequencer states, the row descriptor layout and the
// control and status words passed between the sequencer and the datapath.
package srb_pkg;

	localparam int MAG_BITS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int OP_W      = 2;
	localparam int ROW_W     = 9;
	localparam int START_W   = 10;
	localparam int END_W     = 11;
	localparam int ALU_W     = MAG_BITS + 2;
	localparam int PROD_W    = ALU_W + FRAC_BITS + 1;

	localparam logic [OP_W-1:0] OP_DESC = 2'd0;
	localparam logic [OP_W-1:0] OP_MAG  = 2'd1;
	localparam logic [OP_W-1:0] OP_EVAL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DESC,
		ST_MAX,
		ST_INT_A,
		ST_INT_B,
		ST_INT_MUL,
		ST_INT_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [START_W-1:0]   start_bin;
		logic [END_W-1:0]     end_bin;
		logic                 interp;
		logic [FRAC_BITS-1:0] frac;
	} row_desc_t;

	typedef struct packed {
		state_t state;
		logic   accept;
	} ctrl_t;

	typedef struct packed {
		logic row_ok;
		logic interp;
		logic empty;
		logic more;
	} status_t;

endpackage

[rtl/srb_dp.sv]
// Datapath of the spectrum row binning block: row table, frame store and the
// shared add/subtract unit with the interpolation multiplier.
// Depends on srb_pkg; steered by the state word from srb_seq.
module srb_dp #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_BINS = 1024
) (
	input  logic                           clk,
	input  srb_pkg::ctrl_t                 ctrl,
	input  logic [srb_pkg::OP_W-1:0]       opcode,
	input  logic [srb_pkg::ROW_W-1:0]      row_index,
	input  logic [srb_pkg::START_W-1:0]    range_start,
	input  logic [srb_pkg::END_W-1:0]      range_end,
	input  logic                           interpolate,
	input  logic [srb_pkg::FRAC_BITS-1:0]  fraction,
	input  logic [srb_pkg::START_W-1:0]    bin_address,
	input  logic [srb_pkg::MAG_BITS-1:0]   magnitude,
	output srb_pkg::status_t               status,
	output logic [srb_pkg::MAG_BITS-1:0]   row_amplitude,
	output logic [srb_pkg::ROW_W-1:0]      row_echo
);

	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RIW    = (ROW_AW >= srb_pkg::ROW_W) ? ROW_AW + 1 : srb_pkg::ROW_W + 1;
	localparam int BIN_AW = $clog2(MAX_BINS);
	localparam int IW     = (BIN_AW >= srb_pkg::END_W) ? BIN_AW + 1 : srb_pkg::END_W + 1;

	srb_pkg::row_desc_t row_mem [MAX_ROWS];
	logic [srb_pkg::MAG_BITS-1:0] bin_mem [MAX_BINS];

	srb_pkg::row_desc_t desc_q;
	logic [srb_pkg::MAG_BITS-1:0]  mag_q;
	logic [srb_pkg::MAG_BITS-1:0]  a_q;
	logic [srb_pkg::MAG_BITS-1:0]  amp_q;
	logic [srb_pkg::ROW_W-1:0]     echo_q;
	logic [IW-1:0]                 idx_q;
	logic [IW-1:0]                 end_q;
	logic [srb_pkg::FRAC_BITS-1:0] frac_q;
	logic signed [srb_pkg::ALU_W-1:0]  diff_q;
	logic signed [srb_pkg::PROD_W-1:0] prod_q;

	logic [RIW-1:0]    row_ext;
	logic              row_ok;
	logic [ROW_AW-1:0] row_addr;
	logic [IW-1:0]     bin_ext;
	logic              bin_ok;
	logic [IW-1:0]     start_ext;
	logic [IW-1:0]     end_ext;
	logic [IW-1:0]     end_sat;
	logic [IW-1:0]     rd_idx;
	logic              alu_sub;
	logic [srb_pkg::ALU_W-1:0] alu_a;
	logic [srb_pkg::ALU_W-1:0] alu_b;
	logic [srb_pkg::ALU_W-1:0] alu_res;

	function automatic logic [IW-1:0] sat_idx(input logic [IW-1:0] x);
		logic [IW-1:0] r;
		r = (x >= IW'(MAX_BINS)) ? IW'(MAX_BINS - 1) : x;
		return r;
	endfunction

	always_comb begin
		row_ext   = RIW'(row_index);
		row_ok    = row_ext < RIW'(MAX_ROWS);
		row_addr  = row_ext[ROW_AW-1:0];
		bin_ext   = IW'(bin_address);
		bin_ok    = bin_ext < IW'(MAX_BINS);
		start_ext = IW'(desc_q.start_bin);
		end_ext   = IW'(desc_q.end_bin);
		end_sat   = (end_ext > IW'(MAX_BINS)) ? IW'(MAX_BINS) : end_ext;
	end

	always_comb begin
		unique case (ctrl.state)
			srb_pkg::ST_DESC: rd_idx = sat_idx(start_ext);
			default:          rd_idx = sat_idx(idx_q);
		endcase
	end

	always_comb begin
		unique case (ctrl.state)
			srb_pkg::ST_INT_ADD: begin
				alu_sub = 1'b0;
				alu_a   = {2'b00, a_q};
				alu_b   = prod_q[srb_pkg::FRAC_BITS+srb_pkg::ALU_W-1:srb_pkg::FRAC_BITS];
			end
			srb_pkg::ST_INT_B: begin
				alu_sub = 1'b1;
				alu_a   = {2'b00, mag_q};
				alu_b   = {2'b00, a_q};
			end
			default: begin
				alu_sub = 1'b1;
				alu_a   = {2'b00, mag_q};
				alu_b   = {2'b00, amp_q};
			end
		endcase
		alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && opcode == srb_pkg::OP_DESC && row_ok) begin
			row_mem[row_addr] <= {range_start, range_end, interpolate, fraction};
		end
		if (ctrl.accept && opcode == srb_pkg::OP_EVAL && row_ok) begin
			desc_q <= row_mem[row_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && opcode == srb_pkg::OP_MAG && bin_ok) begin
			bin_mem[bin_ext[BIN_AW-1:0]] <= magnitude;
		end
		mag_q <= bin_mem[rd_idx[BIN_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.state)
			srb_pkg::ST_IDLE: begin
				if (ctrl.accept && opcode == srb_pkg::OP_EVAL) begin
					echo_q <= row_index;
					amp_q  <= '0;
				end
			end
			srb_pkg::ST_DESC: begin
				idx_q  <= start_ext + IW'(1);
				end_q  <= end_sat;
				frac_q <= desc_q.frac;
				amp_q  <= '0;
			end
			srb_pkg::ST_MAX: begin
				idx_q <= idx_q + IW'(1);
				if (!alu_res[srb_pkg::ALU_W-1]) begin
					amp_q <= mag_q;
				end
			end
			srb_pkg::ST_INT_A: begin
				a_q <= mag_q;
			end
			srb_pkg::ST_INT_B: begin
				diff_q <= alu_res;
			end
			srb_pkg::ST_INT_MUL: begin
				prod_q <= diff_q * $signed({1'b0, frac_q});
			end
			srb_pkg::ST_INT_ADD: begin
				amp_q <= alu_res[srb_pkg::MAG_BITS-1:0];
			end
			srb_pkg::ST_DONE: begin
			end
		endcase
	end

	assign status.row_ok = row_ok;
	assign status.interp = desc_q.interp;
	assign status.empty  = start_ext >= end_sat;
	assign status.more   = idx_q < end_q;

	assign row_amplitude = amp_q;
	assign row_echo      = echo_q;

endmodule

[rtl/srb_seq.sv]
// Sequencer of the spectrum row binning block.
// Depends on srb_pkg; drives the state word that steers srb_dp.
module srb_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [srb_pkg::OP_W-1:0] opcode,
	input  srb_pkg::status_t         status,
	output srb_pkg::ctrl_t           ctrl,
	output logic                     busy,
	output logic                     done
);

	srb_pkg::state_t state_q;
	srb_pkg::state_t state_d;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srb_pkg::ST_IDLE: begin
				if (accept && opcode == srb_pkg::OP_EVAL) begin
					state_d = status.row_ok ? srb_pkg::ST_DESC : srb_pkg::ST_DONE;
				end
			end
			srb_pkg::ST_DESC: begin
				priority if (status.interp) begin
					state_d = srb_pkg::ST_INT_A;
				end else if (status.empty) begin
					state_d = srb_pkg::ST_DONE;
				end else begin
					state_d = srb_pkg::ST_MAX;
				end
			end
			srb_pkg::ST_MAX:     state_d = status.more ? srb_pkg::ST_MAX : srb_pkg::ST_DONE;
			srb_pkg::ST_INT_A:   state_d = srb_pkg::ST_INT_B;
			srb_pkg::ST_INT_B:   state_d = srb_pkg::ST_INT_MUL;
			srb_pkg::ST_INT_MUL: state_d = srb_pkg::ST_INT_ADD;
			srb_pkg::ST_INT_ADD: state_d = srb_pkg::ST_DONE;
			srb_pkg::ST_DONE:    state_d = srb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = state_q != srb_pkg::ST_IDLE;
		done         = state_q == srb_pkg::ST_DONE;
		accept       = start && !busy;
		ctrl.state   = state_q;
		ctrl.accept  = accept;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == srb_pkg::OP_EVAL |=> busy)
		else $error("Evaluation word did not start the sequencer.");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode != srb_pkg::OP_EVAL |=> !busy)
		else $error("Write word left the sequencer busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("Sequencer did not return to idle after a result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srb_pkg::ST_MAX && !status.more |=> done)
		else $error("Maximum scan did not end in a result.");

endmodule

[rtl/spectrum_row_binning.sv]
// Top level of the spectrum row binning block.
// Depends on srb_pkg, srb_seq and srb_dp.
//
// A word is taken at a rising edge where start is high and busy is low.
// Opcode 0 stores a row descriptor, opcode 1 stores one bin magnitude and
// opcode 2 evaluates a row; opcode 3 is dropped.  Write words leave busy
// low, so another word may follow at the next edge.
// An evaluation raises busy and returns exactly one result: done is high for
// one cycle with row_amplitude and row_echo valid, and busy falls after it.
// A maximum row over N stored bins holds busy while the frame store gives
// one bin per cycle to the shared compare unit; no new word is taken until
// busy falls.  An interpolating row reads two bins, then subtracts,
// multiplies and adds before the result.  A row beyond the table, or a
// non-interpolating row with an empty range, goes straight to the result.
// The receiver cannot stall: the result is shown for one cycle only.
// Reset returns the sequencer to idle; the row table and frame store keep
// their contents and must be written before they are read.
module spectrum_row_binning #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_BINS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [srb_pkg::OP_W-1:0]       opcode,
	input  logic [srb_pkg::ROW_W-1:0]      row_index,
	input  logic [srb_pkg::START_W-1:0]    range_start,
	input  logic [srb_pkg::END_W-1:0]      range_end,
	input  logic                           interpolate,
	input  logic [srb_pkg::FRAC_BITS-1:0]  fraction,
	input  logic [srb_pkg::START_W-1:0]    bin_address,
	input  logic [srb_pkg::MAG_BITS-1:0]   magnitude,
	output logic                           done,
	output logic [srb_pkg::MAG_BITS-1:0]   row_amplitude,
	output logic [srb_pkg::ROW_W-1:0]      row_echo
);

	srb_pkg::ctrl_t   ctrl;
	srb_pkg::status_t status;

	srb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	srb_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_BINS (MAX_BINS)
	) u_dp (
		.clk           (clk),
		.ctrl          (ctrl),
		.opcode        (opcode),
		.row_index     (row_index),
		.range_start   (range_start),
		.range_end     (range_end),
		.interpolate   (interpolate),
		.fraction      (fraction),
		.bin_address   (bin_address),
		.magnitude     (magnitude),
		.status        (status),
		.row_amplitude (row_amplitude),
		.row_echo      (row_echo)
	);

endmodule
